// ----- rtl/core/hpt_pkg.sv -----
// ----------------------------------------------------------------------------
// hpt_pkg
// Shared types, constants and single-precision helpers for the homogeneous
// point transform pipeline.
// ----------------------------------------------------------------------------
package hpt_pkg;

   // request and response transfers
   typedef struct packed {
      logic        kind;
      logic [31:0] in_x;
      logic [31:0] in_y;
      logic [31:0] in_z;
   } hpt_req_type;

   typedef struct packed {
      logic [31:0] out_x;
      logic [31:0] out_y;
      logic [31:0] out_z;
   } hpt_rsp_type;

   // register file
   localparam int NUM_REGS   = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;

   localparam logic [CSR_IDX_W-1:0] REG_ROW0_COLS01 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ROW0_COLS23 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ROW1_COLS01 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ROW1_COLS23 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ROW2_COLS01 = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_ROW2_COLS23 = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_ROW3_COLS01 = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_ROW3_COLS23 = 3'd7;

   // float constants
   localparam logic [31:0] QNAN   = 32'h7FC0_0000;
   localparam logic [31:0] FP_ONE = 32'h3F80_0000;

   // reciprocal divider: quotient bits and bits retired per stage
   localparam int RECIP_QBITS = 27;
   localparam int RECIP_BPS   = 3;
   localparam int RECIP_STEPS = RECIP_QBITS / RECIP_BPS;

   // register count from request to response register
   localparam int PIPE_DEPTH = 22;

   // identity matrix after reset
   function automatic logic [CSR_DATA_W-1:0] mat_reset_value(input logic [CSR_IDX_W-1:0] idx);
      logic [CSR_DATA_W-1:0] val;
      val = '0;
      unique case (idx)
         REG_ROW0_COLS01: val = {32'h0, FP_ONE};
         REG_ROW1_COLS01: val = {FP_ONE, 32'h0};
         REG_ROW2_COLS23: val = {32'h0, FP_ONE};
         REG_ROW3_COLS23: val = {FP_ONE, 32'h0};
         REG_ROW0_COLS23,
         REG_ROW1_COLS23,
         REG_ROW2_COLS01,
         REG_ROW3_COLS01: val = '0;
         default:         val = '0;
      endcase
      return val;
   endfunction

   function automatic logic fp_is_nan(input logic [31:0] f);
      return (f[30:23] == 8'hFF) && (f[22:0] != 23'd0);
   endfunction

   function automatic logic fp_is_inf(input logic [31:0] f);
      return (f[30:23] == 8'hFF) && (f[22:0] == 23'd0);
   endfunction

   function automatic logic fp_is_zero(input logic [31:0] f);
      return f[30:0] == 31'd0;
   endfunction

   // exponent with subnormals read as 1
   function automatic logic [7:0] fp_exp_eff(input logic [31:0] f);
      return (f[30:23] == 8'd0) ? 8'd1 : f[30:23];
   endfunction

   // significand with hidden bit
   function automatic logic [23:0] fp_sig(input logic [31:0] f);
      return {(f[30:23] != 8'd0), f[22:0]};
   endfunction

   // round sig * 2^lsb_exp to single, nearest even, subnormals kept
   function automatic logic [31:0] fp_round(input logic sign, input logic [47:0] sig,
                                            input logic signed [11:0] lsb_exp);
      int          top;
      int          target;
      int          rsh;
      logic [97:0] ext;
      logic [47:0] kept;
      logic        guard;
      logic        sticky;
      logic        up;
      logic [24:0] mr;
      int          be;
      logic [31:0] res;
      top = 0;
      for (int i = 0; i < 48; i++) begin
         if (sig[i]) top = i;
      end
      target = top + int'(lsb_exp) - 23;
      if (target < -149) target = -149;
      rsh    = target - int'(lsb_exp);
      ext    = '0;
      guard  = 1'b0;
      sticky = 1'b0;
      if (rsh <= 0) begin
         kept = sig << (-rsh);
      end else begin
         ext    = {sig, 50'b0} >> ((rsh > 50) ? 50 : rsh);
         kept   = ext[97:50];
         guard  = ext[49];
         sticky = |ext[48:0];
      end
      up = guard & (sticky | kept[0]);
      mr = kept[24:0] + {24'b0, up};
      if (mr[24]) begin
         mr     = mr >> 1;
         target = target + 1;
      end
      be = mr[23] ? target + 150 : 0;
      if (sig == 48'd0) begin
         res = {sign, 31'd0};
      end else if (be >= 255) begin
         res = {sign, 8'hFF, 23'd0};
      end else begin
         res = {sign, 8'(be), mr[22:0]};
      end
      return res;
   endfunction

endpackage

// ----- rtl/core/hpt_delay.sv -----
// ----------------------------------------------------------------------------
// hpt_delay
// Payload delay line that keeps operands aligned with the float units.
// ----------------------------------------------------------------------------
module hpt_delay #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             adv,
   input  logic [WIDTH-1:0] din,
   output logic [WIDTH-1:0] dout
);

   logic [WIDTH-1:0] tap_ff [DEPTH];

   // shift on pipeline advance
   always_ff @(posedge clock) begin
      if (adv) begin
         tap_ff[0] <= din;
         for (int i = 1; i < DEPTH; i++) begin
            tap_ff[i] <= tap_ff[i-1];
         end
      end
   end

   assign dout = tap_ff[DEPTH-1];

endmodule

// ----- rtl/core/hpt_fmul.sv -----
// ----------------------------------------------------------------------------
// hpt_fmul
// Two-stage single-precision multiplier: significand product, then round.
// ----------------------------------------------------------------------------
module hpt_fmul (
   input  logic        clock,
   input  logic        adv,
   input  logic [31:0] a,
   input  logic [31:0] b,
   output logic [31:0] y
);
   import hpt_pkg::*;

   logic               nan_in, nan_ff;
   logic               inf_in, inf_ff;
   logic               sign_in, sign_ff;
   logic [47:0]        prod_in, prod_ff;
   logic signed [11:0] exp_in, exp_ff;
   logic [31:0]        y_in, y_ff;

   // stage a: special cases and significand product
   always_comb begin
      nan_in  = fp_is_nan(a) || fp_is_nan(b) ||
                (fp_is_inf(a) && fp_is_zero(b)) || (fp_is_zero(a) && fp_is_inf(b));
      inf_in  = fp_is_inf(a) || fp_is_inf(b);
      sign_in = a[31] ^ b[31];
      prod_in = fp_sig(a) * fp_sig(b);
      exp_in  = $signed({4'b0, fp_exp_eff(a)}) + $signed({4'b0, fp_exp_eff(b)}) - 12'sd300;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         nan_ff  <= nan_in;
         inf_ff  <= inf_in;
         sign_ff <= sign_in;
         prod_ff <= prod_in;
         exp_ff  <= exp_in;
      end
   end

   // stage b: normalize and round
   always_comb begin
      if (nan_ff) begin
         y_in = QNAN;
      end else if (inf_ff) begin
         y_in = {sign_ff, 8'hFF, 23'd0};
      end else begin
         y_in = fp_round(sign_ff, prod_ff, exp_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         y_ff <= y_in;
      end
   end

   assign y = y_ff;

endmodule

// ----- rtl/core/hpt_fadd.sv -----
// ----------------------------------------------------------------------------
// hpt_fadd
// Two-stage single-precision adder: align and add, then normalize and round.
// ----------------------------------------------------------------------------
module hpt_fadd (
   input  logic        clock,
   input  logic        adv,
   input  logic [31:0] a,
   input  logic [31:0] b,
   output logic [31:0] y
);
   import hpt_pkg::*;

   logic               nan_in, nan_ff;
   logic               inf_in, inf_ff;
   logic               isign_in, isign_ff;
   logic               sign_in, sign_ff;
   logic [27:0]        sum_in, sum_ff;
   logic signed [11:0] exp_in, exp_ff;
   logic [31:0]        y_in, y_ff;
   logic [31:0]        big, sml;
   logic [7:0]         eb, es, ediff;
   logic [4:0]         dclamp;
   logic [53:0]        ext;
   logic [26:0]        bm, sm;

   // stage a: order by magnitude, align with sticky, add or subtract
   always_comb begin
      nan_in   = fp_is_nan(a) || fp_is_nan(b) ||
                 (fp_is_inf(a) && fp_is_inf(b) && (a[31] != b[31]));
      inf_in   = fp_is_inf(a) || fp_is_inf(b);
      isign_in = fp_is_inf(a) ? a[31] : b[31];
      if (a[30:0] >= b[30:0]) begin
         big = a;
         sml = b;
      end else begin
         big = b;
         sml = a;
      end
      eb     = fp_exp_eff(big);
      es     = fp_exp_eff(sml);
      ediff  = eb - es;
      dclamp = (ediff > 8'd27) ? 5'd27 : ediff[4:0];
      bm     = {fp_sig(big), 3'b0};
      ext    = {fp_sig(sml), 3'b0, 27'b0} >> dclamp;
      sm     = ext[53:27] | {26'b0, |ext[26:0]};
      if (a[31] ^ b[31]) begin
         sum_in = {1'b0, bm} - {1'b0, sm};
      end else begin
         sum_in = {1'b0, bm} + {1'b0, sm};
      end
      sign_in = (sum_in == 28'd0) ? (a[31] & b[31]) : big[31];
      exp_in  = $signed({4'b0, eb}) - 12'sd153;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         nan_ff   <= nan_in;
         inf_ff   <= inf_in;
         isign_ff <= isign_in;
         sign_ff  <= sign_in;
         sum_ff   <= sum_in;
         exp_ff   <= exp_in;
      end
   end

   // stage b: normalize and round
   always_comb begin
      if (nan_ff) begin
         y_in = QNAN;
      end else if (inf_ff) begin
         y_in = {isign_ff, 8'hFF, 23'd0};
      end else begin
         y_in = fp_round(sign_ff, {20'b0, sum_ff}, exp_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         y_ff <= y_in;
      end
   end

   assign y = y_ff;

endmodule

// ----- rtl/core/hpt_frecip.sv -----
// ----------------------------------------------------------------------------
// hpt_frecip
// Pipelined single-precision reciprocal: restoring division of 2^49 by the
// normalized significand, a few quotient bits per stage, then round.
// ----------------------------------------------------------------------------
module hpt_frecip (
   input  logic        clock,
   input  logic        adv,
   input  logic [31:0] a,
   output logic [31:0] y
);
   import hpt_pkg::*;

   logic [25:0]        rem_ff  [RECIP_STEPS+1];
   logic [26:0]        quo_ff  [RECIP_STEPS+1];
   logic [23:0]        div_ff  [RECIP_STEPS+1];
   logic signed [11:0] exp_ff  [RECIP_STEPS+1];
   logic               sign_ff [RECIP_STEPS+1];
   logic               spec_ff [RECIP_STEPS+1];
   logic [31:0]        sval_ff [RECIP_STEPS+1];

   logic               spec_in;
   logic [31:0]        sval_in;
   logic [23:0]        div_in;
   logic signed [11:0] exp_in;
   logic [23:0]        sig_a;
   logic [4:0]         top;
   logic [4:0]         lz;
   logic [31:0]        y_in, y_ff;

   // prep: special cases and significand normalization
   always_comb begin
      sig_a = fp_sig(a);
      top   = 5'd0;
      for (int i = 0; i < 24; i++) begin
         if (sig_a[i]) top = 5'(i);
      end
      lz      = 5'd23 - top;
      div_in  = sig_a << lz;
      exp_in  = 12'sd100 - $signed({4'b0, fp_exp_eff(a)}) + $signed({7'b0, lz});
      spec_in = 1'b1;
      if (fp_is_nan(a)) begin
         sval_in = QNAN;
      end else if (fp_is_inf(a)) begin
         sval_in = {a[31], 31'd0};
      end else if (fp_is_zero(a)) begin
         sval_in = {a[31], 8'hFF, 23'd0};
      end else begin
         spec_in = 1'b0;
         sval_in = QNAN;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0]  <= 26'd1 << 23;
         quo_ff[0]  <= '0;
         div_ff[0]  <= div_in;
         exp_ff[0]  <= exp_in;
         sign_ff[0] <= a[31];
         spec_ff[0] <= spec_in;
         sval_ff[0] <= sval_in;
      end
   end

   // division stages
   for (genvar s = 0; s < RECIP_STEPS; s++) begin : g_div
      logic [25:0] rem_in;
      logic [26:0] quo_in;
      logic        qbit;

      // retire a few quotient bits
      always_comb begin
         rem_in = rem_ff[s];
         quo_in = quo_ff[s];
         qbit   = 1'b0;
         for (int k = 0; k < RECIP_BPS; k++) begin
            qbit = (rem_in >= {2'b0, div_ff[s]});
            if (qbit) rem_in = rem_in - {2'b0, div_ff[s]};
            quo_in = {quo_in[25:0], qbit};
            rem_in = {rem_in[24:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[s+1]  <= rem_in;
            quo_ff[s+1]  <= quo_in;
            div_ff[s+1]  <= div_ff[s];
            exp_ff[s+1]  <= exp_ff[s];
            sign_ff[s+1] <= sign_ff[s];
            spec_ff[s+1] <= spec_ff[s];
            sval_ff[s+1] <= sval_ff[s];
         end
      end
   end

   // round with remainder as sticky
   always_comb begin
      if (spec_ff[RECIP_STEPS]) begin
         y_in = sval_ff[RECIP_STEPS];
      end else begin
         y_in = fp_round(sign_ff[RECIP_STEPS],
                         {20'b0, quo_ff[RECIP_STEPS], |rem_ff[RECIP_STEPS]},
                         exp_ff[RECIP_STEPS]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         y_ff <= y_in;
      end
   end

   assign y = y_ff;

endmodule

// ----- rtl/core/homogeneous_point_transform.sv -----
// ----------------------------------------------------------------------------
// homogeneous_point_transform
// 4x4 single-precision matrix applied to points (with translation and
// perspective divide) and to direction vectors (upper 3x3 only).
//
//   channel   direction  handshake        payload
//   req_      in         valid / stall    hpt_req_type (kind, x, y, z)
//   rsp_      out        valid / stall    hpt_rsp_type (x, y, z)
//   csr_      in         write enable     index, 64-bit data
//
// One transfer per cycle in, one per cycle out unless the response stalls. The
// reciprocal divider (9 stages) is the deepest unit of the pipeline.
// A stalled response freezes the whole pipeline, so req_stall follows rsp_stall
// while the response register holds a result; bubbles are not squeezed out.
// Reset clears the valid chain only; the matrix resets to identity.
// ----------------------------------------------------------------------------
module homogeneous_point_transform (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  hpt_pkg::hpt_req_type               req_payload,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output hpt_pkg::hpt_rsp_type               rsp_payload,
   input  logic                               csr_wr_en,
   input  logic [hpt_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [hpt_pkg::CSR_DATA_W-1:0]     csr_wr_data
);
   import hpt_pkg::*;

   logic [CSR_DATA_W-1:0] mat_ff [NUM_REGS];
   logic [PIPE_DEPTH-1:0] vld_ff, vld_in;
   hpt_rsp_type           rsp_payload_ff, rsp_payload_in;
   logic                  adv;

   logic [31:0] ent    [4][4];
   logic [31:0] coord  [3];
   logic [31:0] prod   [4][3];
   logic [31:0] prod2d [4];
   logic [31:0] sab    [4];
   logic [31:0] dot    [4];
   logic [31:0] pt     [4];
   logic [31:0] ptd    [3];
   logic [31:0] dotd   [3];
   logic [31:0] mres   [3];
   logic [31:0] inv;
   logic        kind_d;
   logic [31:0] sel    [3];

   // matrix registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            mat_ff[i] <= mat_reset_value(CSR_IDX_W'(i));
         end
      end else if (csr_wr_en) begin
         mat_ff[csr_index] <= csr_wr_data;
      end
   end

   // pipeline advance and valid chain
   assign adv       = !(vld_ff[PIPE_DEPTH-1] && rsp_stall);
   assign req_stall = !adv;
   assign vld_in    = {vld_ff[PIPE_DEPTH-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   assign coord[0] = req_payload.in_x;
   assign coord[1] = req_payload.in_y;
   assign coord[2] = req_payload.in_z;

   // per-row dot products plus translation
   for (genvar r = 0; r < 4; r++) begin : g_row
      for (genvar c = 0; c < 4; c++) begin : g_ent
         assign ent[r][c] = mat_ff[r*2 + c/2][(c%2)*32 +: 32];
      end

      for (genvar c = 0; c < 3; c++) begin : g_mul
         hpt_fmul u_mul (
            .clock (clock),
            .adv   (adv),
            .a     (ent[r][c]),
            .b     (coord[c]),
            .y     (prod[r][c])
         );
      end

      hpt_delay #(.WIDTH(32), .DEPTH(2)) u_dly_c (
         .clock (clock),
         .adv   (adv),
         .din   (prod[r][2]),
         .dout  (prod2d[r])
      );

      hpt_fadd u_add_ab (
         .clock (clock),
         .adv   (adv),
         .a     (prod[r][0]),
         .b     (prod[r][1]),
         .y     (sab[r])
      );

      hpt_fadd u_add_c (
         .clock (clock),
         .adv   (adv),
         .a     (sab[r]),
         .b     (prod2d[r]),
         .y     (dot[r])
      );

      hpt_fadd u_add_t (
         .clock (clock),
         .adv   (adv),
         .a     (dot[r]),
         .b     (ent[r][3]),
         .y     (pt[r])
      );
   end

   // reciprocal of w
   hpt_frecip u_recip (
      .clock (clock),
      .adv   (adv),
      .a     (pt[3]),
      .y     (inv)
   );

   // perspective scale, with vector results carried alongside
   for (genvar i = 0; i < 3; i++) begin : g_out
      hpt_delay #(.WIDTH(32), .DEPTH(11)) u_dly_pt (
         .clock (clock),
         .adv   (adv),
         .din   (pt[i]),
         .dout  (ptd[i])
      );

      hpt_delay #(.WIDTH(32), .DEPTH(15)) u_dly_dot (
         .clock (clock),
         .adv   (adv),
         .din   (dot[i]),
         .dout  (dotd[i])
      );

      hpt_fmul u_scale (
         .clock (clock),
         .adv   (adv),
         .a     (ptd[i]),
         .b     (inv),
         .y     (mres[i])
      );

      assign sel[i] = kind_d ? dotd[i] : mres[i];
   end

   hpt_delay #(.WIDTH(1), .DEPTH(PIPE_DEPTH-1)) u_dly_kind (
      .clock (clock),
      .adv   (adv),
      .din   (req_payload.kind),
      .dout  (kind_d)
   );

   // response register with canonical nan
   always_comb begin
      rsp_payload_in.out_x = fp_is_nan(sel[0]) ? QNAN : sel[0];
      rsp_payload_in.out_y = fp_is_nan(sel[1]) ? QNAN : sel[1];
      rsp_payload_in.out_z = fp_is_nan(sel[2]) ? QNAN : sel[2];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = vld_ff[PIPE_DEPTH-1];
   assign rsp_payload = rsp_payload_ff;

   // a frozen pipeline keeps every valid bit
   a_frozen: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(vld_ff))
      else $error("valid chain moved while stalled");

   // reset empties the pipeline
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // every nan leaves as the canonical quiet nan
   a_nan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!fp_is_nan(rsp_payload.out_x) || rsp_payload.out_x == QNAN) &&
                    (!fp_is_nan(rsp_payload.out_y) || rsp_payload.out_y == QNAN) &&
                    (!fp_is_nan(rsp_payload.out_z) || rsp_payload.out_z == QNAN))
      else $error("non-canonical nan on response");

endmodule

// ----- test/homogeneous_point_transform_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// homogeneous_point_transform_tb
// Self-checking bench for the 4x4 single-precision point transform. A
// bit-level float predictor (round to nearest even, subnormals kept, NaNs
// made canonical) computes each result when its request transfer is taken.
// The matrix is reloaded between phases while the pipeline is empty.
// Both channels see random idle bursts, and the last phase runs without them.
// ----------------------------------------------------------------------------
module homogeneous_point_transform_tb;
   import hpt_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int RAND_PHASES    = 8;
   localparam int PHASE_ITEMS    = 92;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   hpt_req_type           req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   hpt_rsp_type           rsp_payload;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wr_data = '0;

   hpt_req_type           pending_points[$];
   hpt_rsp_type           expected_coords[$];
   logic [CSR_DATA_W-1:0] matrix_copy [NUM_REGS];
   bit                    quiet = 1'b0;
   int                    src_gap = 0;
   int                    snk_gap = 0;
   int                    idle_cycles = 0;
   int                    errors = 0;
   int                    n_taken = 0;
   int                    n_checked = 0;
   int                    n_phases = 0;

   homogeneous_point_transform dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------- float math

   function automatic bit is_nan32(input logic [31:0] f);
      return f[30:23] == 8'hFF && f[22:0] != 0;
   endfunction

   function automatic bit is_inf32(input logic [31:0] f);
      return f[30:23] == 8'hFF && f[22:0] == 0;
   endfunction

   function automatic bit is_zero32(input logic [31:0] f);
      return f[30:0] == 0;
   endfunction

   function automatic logic [95:0] mant_of(input logic [31:0] f);
      return 96'({f[30:23] != 0, f[22:0]});
   endfunction

   // exponent of the lowest bit of the significand
   function automatic int scale_of(input logic [31:0] f);
      return (f[30:23] == 0 ? 1 : int'(f[30:23])) - 150;
   endfunction

   // round sign * mag * 2^e to single precision
   function automatic logic [31:0] round_to_single(input logic s, input logic [95:0] mag,
                                                   input int e);
      int          msb;
      int          lsb;
      int          sh;
      int          be;
      logic [95:0] m;
      bit          half;
      bit          sticky;
      msb = -1;
      for (int i = 0; i < 96; i++)
         if (mag[i]) msb = i;
      if (msb < 0) return {s, 31'd0};
      lsb = msb + e - 23;
      if (lsb < -149) lsb = -149;
      sh = lsb - e;
      half = 1'b0;
      sticky = 1'b0;
      if (sh <= 0) begin
         m = mag << (-sh);
      end else if (sh > 96) begin
         m = '0;
         sticky = 1'b1;
      end else begin
         m = mag >> sh;
         half = mag[sh-1];
         sticky = (mag & ((96'd1 << (sh - 1)) - 96'd1)) != 0;
      end
      if (half && (sticky || m[0])) m = m + 96'd1;
      if (m[24]) begin
         m = m >> 1;
         lsb++;
      end
      if (!m[23]) return {s, 8'd0, m[22:0]};
      be = lsb + 150;
      if (be >= 255) return {s, 8'hFF, 23'd0};
      return {s, 8'(be), m[22:0]};
   endfunction

   function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
      logic s;
      s = a[31] ^ b[31];
      if (is_nan32(a) || is_nan32(b)) return QNAN;
      if ((is_inf32(a) && is_zero32(b)) || (is_zero32(a) && is_inf32(b))) return QNAN;
      if (is_inf32(a) || is_inf32(b)) return {s, 8'hFF, 23'd0};
      return round_to_single(s, mant_of(a) * mant_of(b), scale_of(a) + scale_of(b));
   endfunction

   function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] big;
      logic [31:0] lit;
      logic [95:0] mb;
      logic [95:0] ml;
      int          d;
      int          base;
      if (is_nan32(a) || is_nan32(b)) return QNAN;
      if (is_inf32(a) && is_inf32(b)) return (a[31] != b[31]) ? QNAN : a;
      if (is_inf32(a)) return a;
      if (is_inf32(b)) return b;
      if (scale_of(a) >= scale_of(b)) begin
         big = a;
         lit = b;
      end else begin
         big = b;
         lit = a;
      end
      d = scale_of(big) - scale_of(lit);
      // a far smaller operand only acts as sticky below the rounding point
      if (d > 60) begin
         mb = mant_of(big) << 60;
         ml = (mant_of(lit) != 0) ? 96'd1 : 96'd0;
         base = scale_of(big) - 60;
      end else begin
         mb = mant_of(big) << d;
         ml = mant_of(lit);
         base = scale_of(lit);
      end
      if (big[31] == lit[31]) return round_to_single(big[31], mb + ml, base);
      if (mb == ml) return {a[31] & b[31], 31'd0};
      if (mb > ml) return round_to_single(big[31], mb - ml, base);
      return round_to_single(lit[31], ml - mb, base);
   endfunction

   function automatic logic [31:0] fp_recip(input logic [31:0] w);
      logic [95:0] q;
      logic [95:0] r;
      if (is_nan32(w)) return QNAN;
      if (is_inf32(w)) return {w[31], 31'd0};
      if (is_zero32(w)) return {w[31], 8'hFF, 23'd0};
      q = (96'd1 << 80) / mant_of(w);
      r = (96'd1 << 80) % mant_of(w);
      return round_to_single(w[31], {q[94:0], r != 0}, -81 - scale_of(w));
   endfunction

   // ---------------------------------------------------------------- predictor

   function automatic logic [31:0] mat_entry(input int row, input int col);
      return 32'(matrix_copy[row * 2 + col / 2] >> ((col % 2) * 32));
   endfunction

   function automatic logic [31:0] row_dot3(input int row, input hpt_req_type p);
      logic [31:0] acc;
      acc = fp_add(fp_mul(mat_entry(row, 0), p.in_x), fp_mul(mat_entry(row, 1), p.in_y));
      return fp_add(acc, fp_mul(mat_entry(row, 2), p.in_z));
   endfunction

   function automatic logic [31:0] canon(input logic [31:0] f);
      return is_nan32(f) ? QNAN : f;
   endfunction

   function automatic hpt_rsp_type transform_point(input hpt_req_type p);
      logic [31:0] c [4];
      logic [31:0] inv;
      hpt_rsp_type r;
      for (int row = 0; row < 3; row++) c[row] = row_dot3(row, p);
      if (p.kind == 1'b0) begin
         c[3] = fp_add(row_dot3(3, p), mat_entry(3, 3));
         inv = fp_recip(c[3]);
         for (int row = 0; row < 3; row++)
            c[row] = fp_mul(fp_add(c[row], mat_entry(row, 3)), inv);
      end
      r.out_x = canon(c[0]);
      r.out_y = canon(c[1]);
      r.out_z = canon(c[2]);
      return r;
   endfunction

   // ---------------------------------------------------------------- driver

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         src_gap <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_coords.push_back(transform_point(req_payload));
            n_taken++;
         end
         if (!req_valid || !req_stall) begin
            if (src_gap > 0) begin
               src_gap <= src_gap - 1;
               req_valid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
               src_gap <= $urandom_range(0, 5);
               req_valid <= 1'b0;
            end else if (pending_points.size() > 0) begin
               req_payload <= pending_points.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- monitor

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      errors++;
      $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
   endtask

   always @(posedge clock) begin
      hpt_rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         snk_gap <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_coords.size() == 0) begin
               report("unexpected transfer x", rsp_payload.out_x, 32'h0);
            end else begin
               want = expected_coords.pop_front();
               n_checked++;
               if (rsp_payload.out_x !== want.out_x) report("out_x", rsp_payload.out_x, want.out_x);
               if (rsp_payload.out_y !== want.out_y) report("out_y", rsp_payload.out_y, want.out_y);
               if (rsp_payload.out_z !== want.out_z) report("out_z", rsp_payload.out_z, want.out_z);
            end
         end
         if (snk_gap > 0) begin
            snk_gap <= snk_gap - 1;
            rsp_stall <= 1'b1;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            snk_gap <= $urandom_range(0, 5);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
         // watchdog on cycles with no transfer
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en)
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout with %0d results outstanding", expected_coords.size());
            $display("homogeneous_point_transform_tb: done, errors");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------- stimulus

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [63:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= val;
      matrix_copy[idx] = val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // hold the sender until every result is back, then let the pipe empty
   task automatic drain();
      do @(posedge clock);
      while (pending_points.size() != 0 || req_valid || expected_coords.size() != 0);
      repeat (PIPE_DEPTH + 8) @(posedge clock);
      n_phases++;
   endtask

   task automatic add_point(input logic kind, input logic [31:0] x, input logic [31:0] y,
                            input logic [31:0] z);
      hpt_req_type p;
      p.kind = kind;
      p.in_x = x;
      p.in_y = y;
      p.in_z = z;
      pending_points.push_back(p);
   endtask

   // mostly moderate values; wild raises the share of raw bit patterns
   function automatic logic [31:0] rand_fp(input int wild);
      int sel;
      sel = $urandom_range(0, 15);
      if (sel < wild) return $urandom;
      if (sel == 15) begin
         case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'h8000_0000;
            2: return 32'h7F80_0000;
            3: return 32'hFF80_0000;
            4: return {$urandom_range(0, 1) == 1, 8'hFF, 23'($urandom_range(1, 32'h7F_FFFF))};
            5: return {$urandom_range(0, 1) == 1, 8'h00, 23'($urandom)};
            6: return 32'h7F7F_FFFF;
            default: return {$urandom_range(0, 1) == 1, 8'($urandom_range(1, 20)), 23'($urandom)};
         endcase
      end
      return {$urandom_range(0, 1) == 1, 8'($urandom_range(118, 136)), 23'($urandom)};
   endfunction

   initial begin
      for (int i = 0; i < NUM_REGS; i++) matrix_copy[i] = mat_reset_value(CSR_IDX_W'(i));
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // identity after reset: plain values, extremes and specials
      add_point(1'b0, 32'h3F80_0000, 32'h4000_0000, 32'h4040_0000);
      add_point(1'b1, 32'hBF80_0000, 32'h4000_0000, 32'hC040_0000);
      add_point(1'b0, 32'h0000_0000, 32'h8000_0000, 32'h0000_0000);
      add_point(1'b0, 32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h0080_0000);
      add_point(1'b0, 32'hFFFF_FFFF, 32'h7F80_0000, 32'hFF80_0000);
      add_point(1'b1, 32'h0000_0001, 32'h807F_FFFF, 32'h7FC0_0001);
      add_point(1'b0, 32'h0000_0001, 32'h807F_FFFF, 32'h0000_0000);
      add_point(1'b1, 32'h7F80_0000, 32'hFF80_0000, 32'hFFFF_FFFF);
      drain();

      // w follows z: zero w gives infinite reciprocal, translation added
      write_reg(REG_ROW0_COLS23, {32'h4040_0000, 32'h0000_0000});
      write_reg(REG_ROW1_COLS23, {32'hC000_0000, 32'h0000_0000});
      write_reg(REG_ROW3_COLS23, {32'h0000_0000, FP_ONE});
      add_point(1'b0, 32'h3F80_0000, 32'h3F80_0000, 32'h0000_0000);
      add_point(1'b0, 32'h3F80_0000, 32'h3F80_0000, 32'h8000_0000);
      add_point(1'b0, 32'h4040_0000, 32'hC000_0000, 32'h0000_0000);
      add_point(1'b0, 32'h3F80_0000, 32'h3F80_0000, 32'h0000_0001);
      add_point(1'b0, 32'h3F80_0000, 32'h3F80_0000, 32'h7F7F_FFFF);
      add_point(1'b0, 32'h3F80_0000, 32'h3F80_0000, 32'h4000_0000);
      add_point(1'b1, 32'h3F80_0000, 32'h3F80_0000, 32'h0000_0000);
      drain();

      // register extremes: all ones (NaN entries) and all zeros
      for (int i = 0; i < NUM_REGS; i++) write_reg(CSR_IDX_W'(i), '1);
      add_point(1'b0, 32'h3F80_0000, 32'h0000_0000, 32'hFFFF_FFFF);
      add_point(1'b1, 32'h3F80_0000, 32'h0000_0000, 32'h4000_0000);
      drain();
      for (int i = 0; i < NUM_REGS; i++) write_reg(CSR_IDX_W'(i), '0);
      add_point(1'b0, 32'h3F80_0000, 32'h4000_0000, 32'h4040_0000);
      add_point(1'b1, 32'h3F80_0000, 32'h4000_0000, 32'h4040_0000);
      drain();

      // random matrices and points; the last phase runs with no idling
      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         if (ph == RAND_PHASES - 1) quiet = 1'b1;
         for (int i = 0; i < NUM_REGS; i++)
            write_reg(CSR_IDX_W'(i), {rand_fp(ph % 2 ? 6 : 0), rand_fp(ph % 2 ? 6 : 0)});
         for (int n = 0; n < PHASE_ITEMS; n++)
            add_point($urandom_range(0, 1) == 1, rand_fp(3), rand_fp(3), rand_fp(3));
         drain();
      end

      $display("%0d points transformed and %0d results checked over %0d matrix phases",
               n_taken, n_checked, n_phases);
      $display("covered identity, projective w=0, NaN and zero matrices, random matrices");
      if (errors == 0)
         $display("homogeneous_point_transform_tb: done, clean");
      else
         $display("homogeneous_point_transform_tb: done, errors");
      $finish;
   end

endmodule
